// ----- rtl/rbf_pkg.sv -----
// Shared types and constants of the ring buffer FIFO.
package rbf_pkg;

    localparam int CFG_W    = 9;
    localparam int WORD_W   = 16;
    localparam int OP_W     = 2;
    localparam int STAT_W   = 2;
    localparam int EXT_W    = 17;
    localparam int CAP_MAX  = 511;
    localparam int CAP_RST  = 256;

    localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
    localparam logic [OP_W-1:0] OP_GET   = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic exec;
        logic load_cfg;
    } rbf_cmd_t;

endpackage

// ----- rtl/rbf_ctrl.sv -----
// Handshake controller of the ring buffer FIFO.
module rbf_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  logic              cfg_wr_en,
    output rbf_pkg::rbf_cmd_t cmd
);
    import rbf_pkg::*;

    typedef enum logic {
        IDLE,
        SEND
    } state_t;

    state_t state_reg;
    logic   s_tready_reg;
    logic   m_tvalid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= IDLE;
            s_tready_reg <= 1'b1;
            m_tvalid_reg <= 1'b0;
        end else begin
            case (state_reg)
                IDLE: begin
                    if (s_tvalid) begin
                        state_reg    <= SEND;
                        s_tready_reg <= 1'b0;
                        m_tvalid_reg <= 1'b1;
                    end
                end
                SEND: begin
                    if (m_tready) begin
                        state_reg    <= IDLE;
                        s_tready_reg <= 1'b1;
                        m_tvalid_reg <= 1'b0;
                    end
                end
                default: begin
                    state_reg    <= IDLE;
                    s_tready_reg <= 1'b1;
                    m_tvalid_reg <= 1'b0;
                end
            endcase
        end
    end

    assign s_tready = s_tready_reg;
    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        cmd.exec     = s_tvalid && s_tready_reg;
        cmd.load_cfg = cfg_wr_en;
    end

endmodule

// ----- rtl/rbf_datapath.sv -----
// Storage, pointers, count and result registers of the ring buffer FIFO.
module rbf_datapath #(
    parameter int DEPTH = 256
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  rbf_pkg::rbf_cmd_t           cmd,
    input  logic [rbf_pkg::OP_W-1:0]    opcode,
    input  logic [rbf_pkg::WORD_W-1:0]  put_value,
    input  logic [rbf_pkg::CFG_W-1:0]   cfg_wr_data,
    output logic [rbf_pkg::WORD_W-1:0]  get_value,
    output logic [rbf_pkg::STAT_W-1:0]  status,
    output logic [rbf_pkg::CFG_W-1:0]   fill_level,
    output logic                        empty_flag,
    output logic                        full_flag
);
    import rbf_pkg::*;

    localparam int PW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CAP_LIMIT = (DEPTH < CAP_MAX) ? DEPTH : CAP_MAX;

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rdata_reg;

    logic [CFG_W-1:0]  cap_reg;
    logic [PW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CFG_W-1:0]  count_reg, count_next;
    logic [STAT_W-1:0] status_reg, status_next;
    logic              got_reg, got_next;

    logic [CFG_W-1:0]  eff_cap;
    logic              is_full, is_empty;
    logic              do_put, do_get;
    logic              wr_wrap, rd_wrap;

    always_comb begin
        if (cap_reg == '0) begin
            eff_cap = CFG_W'(1);
        end else if (cap_reg > CFG_W'(CAP_LIMIT)) begin
            eff_cap = CFG_W'(CAP_LIMIT);
        end else begin
            eff_cap = cap_reg;
        end
    end

    assign is_full  = count_reg >= eff_cap;
    assign is_empty = count_reg == '0;
    assign do_put   = cmd.exec && (opcode == OP_PUT) && !is_full;
    assign do_get   = cmd.exec && (opcode == OP_GET) && !is_empty;

    assign wr_wrap = ({{(EXT_W-PW){1'b0}}, wr_ptr_reg} + EXT_W'(1))
                     >= {{(EXT_W-CFG_W){1'b0}}, eff_cap};
    assign rd_wrap = ({{(EXT_W-PW){1'b0}}, rd_ptr_reg} + EXT_W'(1))
                     >= {{(EXT_W-CFG_W){1'b0}}, eff_cap};

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        status_next = status_reg;
        got_next    = got_reg;
        if (cmd.load_cfg) begin
            wr_ptr_next = '0;
            rd_ptr_next = '0;
            count_next  = '0;
        end else if (cmd.exec) begin
            status_next = ST_DONE;
            got_next    = 1'b0;
            case (opcode)
                OP_PUT: begin
                    if (is_full) begin
                        status_next = ST_FULL;
                    end else begin
                        wr_ptr_next = wr_wrap ? '0 : wr_ptr_reg + PW'(1);
                        count_next  = count_reg + CFG_W'(1);
                    end
                end
                OP_GET: begin
                    if (is_empty) begin
                        status_next = ST_EMPTY;
                    end else begin
                        rd_ptr_next = rd_wrap ? '0 : rd_ptr_reg + PW'(1);
                        count_next  = count_reg - CFG_W'(1);
                        got_next    = 1'b1;
                    end
                end
                OP_CLEAR: begin
                    wr_ptr_next = '0;
                    rd_ptr_next = '0;
                    count_next  = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg    <= CFG_W'(CAP_RST);
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            status_reg <= ST_DONE;
            got_reg    <= 1'b0;
        end else begin
            if (cmd.load_cfg) begin
                cap_reg <= cfg_wr_data;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            status_reg <= status_next;
            got_reg    <= got_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_put) begin
            mem[wr_ptr_reg] <= put_value;
        end
        if (do_get) begin
            rdata_reg <= mem[rd_ptr_reg];
        end
    end

    assign get_value  = got_reg ? rdata_reg : '0;
    assign status     = status_reg;
    assign fill_level = count_reg;
    assign empty_flag = is_empty;
    assign full_flag  = count_reg == eff_cap;

endmodule

// ----- rtl/ring_buffer_fifo.sv -----
// Top level of the ring buffer FIFO: controller and datapath.
//
//  channel  dir  handshake            payload
//  s_       in   s_tvalid/s_tready    tuser: opcode; tdata: put_value
//  m_       out  m_tvalid/m_tready    tuser: status; tdata: get_value, level, flags
//  cfg_     in   cfg_wr_en            cfg_wr_data: usable_capacity
//
// In each beat the accept cycle updates pointers, count and the storage port, and
// the next cycle presents the result from the registered read. A stalled result
// holds until taken, but for level and flags on a capacity write; no beat is
// accepted meanwhile. Reset empties the buffer and sets the capacity to 256;
// storage is not cleared. A capacity write also empties the buffer.
module ring_buffer_fifo #(
    parameter int DEPTH = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] put_value
    input  logic [1:0]  s_tuser,   // [1:0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [15:0] get_value, [24:16] fill_level,
                                   // [25] empty_flag, [26] full_flag, rest zero
    output logic [1:0]  m_tuser,   // [1:0] status
    input  logic        cfg_wr_en,
    input  logic [8:0]  cfg_wr_data
);
    import rbf_pkg::*;

    rbf_cmd_t          cmd;
    logic [WORD_W-1:0] get_value;
    logic [STAT_W-1:0] status;
    logic [CFG_W-1:0]  fill_level;
    logic              empty_flag;
    logic              full_flag;

    rbf_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_wr_en (cfg_wr_en),
        .cmd       (cmd)
    );

    rbf_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .opcode      (s_tuser),
        .put_value   (s_tdata),
        .cfg_wr_data (cfg_wr_data),
        .get_value   (get_value),
        .status      (status),
        .fill_level  (fill_level),
        .empty_flag  (empty_flag),
        .full_flag   (full_flag)
    );

    assign m_tdata = {5'd0, full_flag, empty_flag, fill_level, get_value};
    assign m_tuser = status;

endmodule

// ----- rtl/rbf_checker.sv -----
// Port-level checks of the ring buffer FIFO and their binding.
module rbf_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [1:0]  m_tuser
);
    import rbf_pkg::*;

    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input taken while a result waits");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted beat gave no result");

    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[25] && m_tdata[26]))
        else $error("empty and full together");

    a_empty_get: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ST_EMPTY) |-> (m_tdata[15:0] == '0) && m_tdata[25])
        else $error("get on empty returned data");

endmodule

bind ring_buffer_fifo rbf_checker u_rbf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ----- tb/ring_buffer_fifo_tb.sv -----
// Testbench for ring_buffer_fifo: directed and random beats checked against a FIFO model.
`timescale 1ns / 100ps

module ring_buffer_fifo_tb;

    import rbf_pkg::*;

    localparam int              BUF_DEPTH = 256;
    localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic [STAT_W-1:0] status;
        logic [8:0]        level;
        logic              empty;
        logic              full;
    } fifo_result_t;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata     = '0;
    logic [1:0]  s_tuser     = '0;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_wr_en   = 1'b0;
    logic [8:0]  cfg_wr_data = '0;

    // FIFO model state
    logic [WORD_W-1:0] fifo_mem [0:BUF_DEPTH-1];
    int                wr_ptr;
    int                rd_ptr;
    int                fill;
    int                cap_reg;
    fifo_result_t      expected_results [$];

    int                mismatch_count = 0;
    int                burst_left     = 0;

    int                ready_mode = 0;
    int                ready_hold = 0;
    logic [6:0]        ready_pat  = 7'b1011001;

    ring_buffer_fifo i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic int cap_in_force();
        if (cap_reg < 1) return 1;
        if (cap_reg > BUF_DEPTH) return BUF_DEPTH;
        return cap_reg;
    endfunction

    function automatic int next_slot(input int ptr);
        return (ptr + 1 >= cap_in_force()) ? 0 : ptr + 1;
    endfunction

    task automatic predict_beat(input logic [1:0] op, input logic [15:0] value);
        fifo_result_t r;
        r = '0;
        r.status = ST_DONE;
        case (op)
            OP_PUT: begin
                if (fill >= cap_in_force()) begin
                    r.status = ST_FULL;
                end else begin
                    fifo_mem[wr_ptr] = value;
                    wr_ptr = next_slot(wr_ptr);
                    fill++;
                end
            end
            OP_GET: begin
                if (fill == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.word = fifo_mem[rd_ptr];
                    rd_ptr = next_slot(rd_ptr);
                    fill--;
                end
            end
            OP_CLEAR: begin
                wr_ptr = 0;
                rd_ptr = 0;
                fill   = 0;
            end
            default: begin
            end
        endcase
        r.level = fill[8:0];
        r.empty = (fill == 0);
        r.full  = (fill == cap_in_force());
        expected_results.push_back(r);
    endtask

    task automatic send_beat(input logic [1:0] op, input logic [15:0] value);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= op;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_beat(op, value);
        burst_left--;
    endtask

    task automatic wait_idle();
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_capacity(input logic [8:0] cap);
        s_tvalid  <= 1'b0;
        burst_left = 0;
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= cap;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cap_reg = int'(cap);
        wr_ptr  = 0;
        rd_ptr  = 0;
        fill    = 0;
    endtask

    task automatic test_after_reset();
        send_beat(OP_GET,   16'h0000);
        send_beat(OP_PUT,   16'h0000);
        send_beat(OP_PUT,   16'hFFFF);
        send_beat(OP_NONE,  16'hFFFF);
        send_beat(OP_GET,   16'hFFFF);
        send_beat(OP_GET,   16'h0000);
        send_beat(OP_GET,   16'h0000);
        send_beat(OP_PUT,   16'h1234);
        send_beat(OP_CLEAR, 16'hFFFF);
        send_beat(OP_GET,   16'h0000);
    endtask

    task automatic test_capacity_limits();
        write_capacity(9'd0);
        send_beat(OP_PUT, 16'hA5A5);
        send_beat(OP_PUT, 16'h5A5A);
        send_beat(OP_GET, 16'h0000);
        send_beat(OP_GET, 16'h0000);
        write_capacity(9'd2);
        send_beat(OP_PUT, 16'h8001);
        send_beat(OP_PUT, 16'h7FFE);
        send_beat(OP_PUT, 16'hFFFF);
        send_beat(OP_GET, 16'h0000);
        send_beat(OP_PUT, 16'h0001);
        send_beat(OP_GET, 16'h0000);
        send_beat(OP_GET, 16'h0000);
        write_capacity(9'd511);
        send_beat(OP_PUT, 16'hFFFF);
        // capacity write drops the stored word
        write_capacity(9'd1);
        send_beat(OP_GET, 16'h0000);
    endtask

    task automatic test_random_phase(input logic [8:0] cap, input int n_items,
                                     input int clear_pct);
        int          r;
        bit          filling;
        logic [1:0]  op;
        logic [15:0] value;
        write_capacity(cap);
        filling = 1'b1;
        for (int i = 0; i < n_items; i++) begin
            if (fill >= cap_in_force()) begin
                filling = 1'b0;
            end else if (fill == 0) begin
                filling = 1'b1;
            end else if ($urandom_range(0, 99) == 0) begin
                filling = !filling;
            end
            r = $urandom_range(0, 99);
            if (r < clear_pct) begin
                op = OP_CLEAR;
            end else if (r < clear_pct + 3) begin
                op = OP_NONE;
            end else if ($urandom_range(0, 9) < 9) begin
                op = filling ? OP_PUT : OP_GET;
            end else begin
                op = filling ? OP_GET : OP_PUT;
            end
            case ($urandom_range(0, 15))
                0:       value = 16'h0000;
                1:       value = 16'hFFFF;
                default: value = 16'($urandom_range(0, 16'hFFFF));
            endcase
            send_beat(op, value);
        end
    endtask

    task automatic test_random_capacities();
        test_random_phase(9'd256, 500, 0);
        test_random_phase(9'd1,   150, 3);
        test_random_phase(9'd2,   150, 3);
        test_random_phase(9'd0,   100, 3);
        test_random_phase(9'd511, 350, 0);
        test_random_phase(9'd257, 100, 2);
        repeat (3) test_random_phase(9'($urandom_range(3, 255)), 150, 3);
    endtask

    // receiver stall pattern
    always @(posedge aclk) begin
        if (ready_hold == 0) begin
            ready_mode <= $urandom_range(0, 3);
            ready_hold <= $urandom_range(64, 256);
        end else begin
            ready_hold <= ready_hold - 1;
        end
        case (ready_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= ready_pat[0];
        endcase
        ready_pat <= {ready_pat[0], ready_pat[6:1]};
    end

    always @(posedge aclk) begin : check_results
        fifo_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                $error("result beat with no expected result: tdata %h tuser %h",
                       m_tdata, m_tuser);
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                if (m_tdata[15:0] !== want.word) begin
                    $error("get_value: expected %h, actual %h", want.word, m_tdata[15:0]);
                    mismatch_count++;
                end
                if (m_tuser !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, m_tuser);
                    mismatch_count++;
                end
                if (m_tdata[24:16] !== want.level) begin
                    $error("fill_level: expected %0d, actual %0d", want.level,
                           m_tdata[24:16]);
                    mismatch_count++;
                end
                if (m_tdata[25] !== want.empty) begin
                    $error("empty_flag: expected %b, actual %b", want.empty, m_tdata[25]);
                    mismatch_count++;
                end
                if (m_tdata[26] !== want.full) begin
                    $error("full_flag: expected %b, actual %b", want.full, m_tdata[26]);
                    mismatch_count++;
                end
                if (m_tdata[31:27] !== 5'd0) begin
                    $error("tdata padding: expected %h, actual %h", 5'd0, m_tdata[31:27]);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        wr_ptr  = 0;
        rd_ptr  = 0;
        fill    = 0;
        cap_reg = CAP_RST;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_after_reset();
        test_capacity_limits();
        test_random_capacities();

        s_tvalid <= 1'b0;
        wait_idle();
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ----- ring_buffer_fifo.f -----
rtl/rbf_pkg.sv
rtl/rbf_ctrl.sv
rtl/rbf_datapath.sv
rtl/ring_buffer_fifo.sv
rtl/rbf_checker.sv
tb/ring_buffer_fifo_tb.sv
